/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files of the truth table cofactor analyzer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTCA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTCA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ttca_pkg.sv */
// Package with the types, constants and table functions of the cofactor analyzer.
`timescale 1ns / 1ps

package ttca_pkg;

    localparam int TT_MAX_INPUTS = 6;
    localparam int TT_WIDTH      = 1 << TT_MAX_INPUTS;

    typedef logic [TT_WIDTH-1:0] tt_word_t;

    typedef struct packed {
        tt_word_t   truth_table;
        logic [2:0] input_count;
        logic [2:0] var_index;
        logic       cofactor_value;
        logic       forced_input_value;
        logic       forced_output_value;
    } tt_req_t;

    typedef struct packed {
        logic is_dont_care;
        logic always_toggles;
        logic forces_output;
    } tt_checks_t;

    function automatic tt_word_t var_mask(input logic [2:0] v);
        tt_word_t m;
        case (v)
            3'd0:    m = 64'hAAAA_AAAA_AAAA_AAAA;
            3'd1:    m = 64'hCCCC_CCCC_CCCC_CCCC;
            3'd2:    m = 64'hF0F0_F0F0_F0F0_F0F0;
            3'd3:    m = 64'hFF00_FF00_FF00_FF00;
            3'd4:    m = 64'hFFFF_0000_FFFF_0000;
            3'd5:    m = 64'hFFFF_FFFF_0000_0000;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic tt_word_t size_mask(input logic [2:0] n);
        tt_word_t m;
        case (n)
            3'd0:    m = 64'h0000_0000_0000_0001;
            3'd1:    m = 64'h0000_0000_0000_0003;
            3'd2:    m = 64'h0000_0000_0000_000F;
            3'd3:    m = 64'h0000_0000_0000_00FF;
            3'd4:    m = 64'h0000_0000_0000_FFFF;
            3'd5:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/ttca_cofactor_unit.sv */
// Cofactor, variable inversion and the don't-care, toggle and forcing checks.
`timescale 1ns / 1ps

module ttca_cofactor_unit
    import ttca_pkg::*;
(
    input  tt_req_t    req,
    output tt_word_t   cofactor_table,
    output tt_word_t   flipped_table,
    output tt_checks_t checks
);

    tt_word_t   t;
    tt_word_t   m;
    tt_word_t   diff;
    tt_word_t   sel;
    tt_word_t   comp;
    tt_word_t   hi_part;
    tt_word_t   lo_part;
    logic [5:0] shamt;
    logic       in_word;

    always_comb
    begin
        t       = req.truth_table;
        m       = var_mask(req.var_index);
        in_word = (req.var_index < 3'(TT_MAX_INPUTS));
        shamt   = 6'd1 << req.var_index;
        comp    = req.forced_output_value ? '1 : '0;
        hi_part = t & m;
        lo_part = t & ~m;
        diff    = (t << shamt) ^ t;
        sel     = req.forced_input_value ? m : ~m;

        if (in_word)
        begin
            if (req.cofactor_value)
            begin
                cofactor_table = hi_part | (hi_part >> shamt);
            end
            else
            begin
                cofactor_table = lo_part | (lo_part << shamt);
            end
            flipped_table         = (lo_part << shamt) | (hi_part >> shamt);
            checks.is_dont_care   = ((diff & m) == '0);
            checks.always_toggles = ((diff | ~m) == '1);
            checks.forces_output  = (((t ^ comp) & sel) == '0);
        end
        else
        begin
            cofactor_table        = t;
            flipped_table         = t;
            checks.is_dont_care   = 1'b1;
            checks.always_toggles = 1'b0;
            checks.forces_output  = ((t ^ comp) == '0);
        end
    end

endmodule

/* hw/rtl/ttca_and_detect.sv */
// Generalized AND detection: one minterm or one maxterm within the used table bits, or no inputs.
`timescale 1ns / 1ps

module ttca_and_detect
    import ttca_pkg::*;
(
    input  tt_word_t   truth_table,
    input  logic [2:0] input_count,
    output logic       is_generalized_and
);

    tt_word_t ones;
    tt_word_t zeros;
    logic     one_minterm;
    logic     one_maxterm;

    always_comb
    begin
        ones        = truth_table & size_mask(input_count);
        zeros       = ~truth_table & size_mask(input_count);
        one_minterm = (ones != '0) && ((ones & (ones - tt_word_t'(1))) == '0);
        one_maxterm = (zeros != '0) && ((zeros & (zeros - tt_word_t'(1))) == '0);
        is_generalized_and = (input_count == 3'd0) || one_minterm || one_maxterm;
    end

endmodule

/* hw/rtl/truth_table_cofactor_analyzer.sv */
// Top level of the six-input truth table cofactor and dependency analyzer.
// The block takes one truth table beat per cycle while the output side takes every result, and
// returns one result beat for each, in order. Every beat passes through an input register and
// a result register with the full analysis in between; a result beat is presented once it is
// written into the result register, and the input side is ready whenever the input register is
// empty or can move on. A stalled output holds two beats before the input stalls.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module truth_table_cofactor_analyzer
    import ttca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tt_word_t   truth_table,
    input  logic [2:0] input_count,
    input  logic [2:0] var_index,
    input  logic       cofactor_value,
    input  logic       forced_input_value,
    input  logic       forced_output_value,
    output logic       out_valid,
    input  logic       out_ready,
    output tt_word_t   cofactor_table,
    output tt_word_t   flipped_table,
    output logic       is_dont_care,
    output logic       always_toggles,
    output logic       forces_output,
    output logic       is_generalized_and
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    tt_req_t    s1_req_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    tt_word_t   out_cof_reg;
    tt_word_t   out_flip_reg;
    tt_checks_t out_checks_reg;
    logic       out_gand_reg;

    tt_word_t   cof_w;
    tt_word_t   flip_w;
    tt_checks_t checks_w;
    logic       gand_w;
    logic       out_adv;
    logic       s1_adv;

    ttca_cofactor_unit u_cofactor
    (
        .req            (s1_req_reg),
        .cofactor_table (cof_w),
        .flipped_table  (flip_w),
        .checks         (checks_w)
    );

    ttca_and_detect u_and_detect
    (
        .truth_table        (s1_req_reg.truth_table),
        .input_count        (s1_req_reg.input_count),
        .is_generalized_and (gand_w)
    );

    always_comb
    begin
        out_adv        = !out_valid_reg || out_ready;
        s1_adv         = !s1_valid_reg || out_adv;
        s1_valid_next  = s1_adv ? in_valid : s1_valid_reg;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_req_reg.truth_table         <= truth_table;
            s1_req_reg.input_count         <= input_count;
            s1_req_reg.var_index           <= var_index;
            s1_req_reg.cofactor_value      <= cofactor_value;
            s1_req_reg.forced_input_value  <= forced_input_value;
            s1_req_reg.forced_output_value <= forced_output_value;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_cof_reg    <= cof_w;
            out_flip_reg   <= flip_w;
            out_checks_reg <= checks_w;
            out_gand_reg   <= gand_w;
        end
    end

    assign in_ready           = s1_adv;
    assign out_valid          = out_valid_reg;
    assign cofactor_table     = out_cof_reg;
    assign flipped_table      = out_flip_reg;
    assign is_dont_care       = out_checks_reg.is_dont_care;
    assign always_toggles     = out_checks_reg.always_toggles;
    assign forces_output      = out_checks_reg.forces_output;
    assign is_generalized_and = out_gand_reg;

    `TTCA_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid_reg, in_ready, "input not ready while result register is empty")
    `TTCA_ASSERT_IMPL(a_dc_excludes_toggle, clk, rst_n, out_valid_reg && out_checks_reg.is_dont_care, !out_checks_reg.always_toggles, "don't-care and always-toggles both set")
    `TTCA_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_valid && in_ready, s1_valid_reg, "accepted beat did not reach the input register")
    `TTCA_ASSERT_NEXT(a_stall_holds_stage, clk, rst_n, s1_valid_reg && !out_adv, s1_valid_reg && $stable(s1_req_reg), "stalled input register lost or changed its beat")

endmodule
